### sv/sci_pkg.sv
`timescale 1ns / 1ps
// Shared types and codes for the segment / curve intersection test.
// No dependencies; imported by every module of the block.
package sci_pkg;

  localparam logic [1:0] KIND_QSTART = 2'd0;
  localparam logic [1:0] KIND_QEND   = 2'd1;
  localparam logic [1:0] KIND_VERTEX = 2'd2;

  typedef logic [1:0] ori_t;
  localparam ori_t ORI_COL = 2'd0;
  localparam ori_t ORI_CW  = 2'd1;
  localparam ori_t ORI_CCW = 2'd2;

  localparam int  PADDR_W        = 3;
  localparam int  PDATA_W        = 32;
  localparam int  EPS_W          = 32;
  localparam logic REG_ORIENT_EPS = 1'b0;

  // a1/a2: curve segment, b1/b2: query segment
  typedef struct packed {
    logic tested;
    logic last;
    logic overlap;
    logic id_a1b1;
    logic id_a1b2;
    logic id_a2b1;
    logic id_a2b2;
  } pair_flags_t;

  typedef struct packed {
    ori_t [3:0] ori;
    logic [1:0] far;
  } pair_class_t;

endpackage

### sv/segment_curve_intersection_test.sv
`timescale 1ns / 1ps
// Tests a query segment against a streamed polyline. Items of kind 0 and 1 load the
// query endpoints, items of kind 2 are curve vertices; each vertex pair whose y range
// overlaps the query is checked with thresholded orientations (orient_epsilon) and
// exact squared-length compares, and the vertex marked last returns the sticky hit
// flag. One item is taken every cycle while item_stall is low. The transfer of the
// last vertex loads the operand register; the product, sign and result registers
// follow in that order, the last one holding the result. Input stalls only when the
// operand, product and sign registers are all full, the sign register holds a last
// vertex and a result waits under stall at the output. Depends on sci_pkg and the sci_* stages.
module segment_curve_intersection_test import sci_pkg::*; #(
  parameter int COORD_BITS = 16,
  parameter int ID_BITS    = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         item_valid,
  output logic                         item_stall,
  input  logic [1:0]                   kind,
  input  logic signed [COORD_BITS-1:0] coord_x,
  input  logic signed [COORD_BITS-1:0] coord_y,
  input  logic [ID_BITS-1:0]           vertex_id,
  input  logic                         last,
  output logic                         result_valid,
  input  logic                         result_stall,
  output logic                         intersects,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [PADDR_W-1:0]           paddr,
  input  logic [PDATA_W-1:0]           pwdata,
  output logic [PDATA_W-1:0]           prdata,
  output logic                         pready
);

  localparam int PW = 2 * COORD_BITS + 2;

  logic [EPS_W-1:0] orient_epsilon;
  logic             accept, ready1, ready2, ready3;
  logic             s1_valid, s2_valid, s3_valid;

  logic signed [COORD_BITS-1:0] a1_x, a1_y, a2_x, a2_y, b1_x, b1_y, b2_x, b2_y;
  pair_flags_t                  s1_flags, s2_flags, s3_flags;
  pair_class_t                  s3_class;

  logic signed [PW-1:0] ori_pa [4];
  logic signed [PW-1:0] ori_pb [4];
  logic signed [PW-1:0] u_xx, u_yy;
  logic signed [PW-1:0] dot_x [2];
  logic signed [PW-1:0] dot_y [2];
  logic signed [PW-1:0] v_xx [2];
  logic signed [PW-1:0] v_yy [2];

  // register file
  assign pready = 1'b1;
  assign prdata = (paddr[PADDR_W-1] == REG_ORIENT_EPS) ? PDATA_W'(orient_epsilon) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      orient_epsilon <= '0;
    end else if (psel && penable && pwrite && pready &&
                 paddr[PADDR_W-1] == REG_ORIENT_EPS) begin
      orient_epsilon <= pwdata[EPS_W-1:0];
    end
  end

  // stage flow control
  assign ready2     = !s2_valid || ready3;
  assign ready1     = !s1_valid || ready2;
  assign item_stall = !ready1;
  assign accept     = item_valid && ready1;

  sci_capture #(
    .COORD_BITS(COORD_BITS),
    .ID_BITS   (ID_BITS)
  ) u_capture (
    .clk      (clk),
    .rst      (rst),
    .accept   (accept),
    .load     (ready1),
    .kind     (kind),
    .coord_x  (coord_x),
    .coord_y  (coord_y),
    .vertex_id(vertex_id),
    .last     (last),
    .s1_valid (s1_valid),
    .a1_x     (a1_x),
    .a1_y     (a1_y),
    .a2_x     (a2_x),
    .a2_y     (a2_y),
    .b1_x     (b1_x),
    .b1_y     (b1_y),
    .b2_x     (b2_x),
    .b2_y     (b2_y),
    .s1_flags (s1_flags)
  );

  sci_products #(
    .COORD_BITS(COORD_BITS),
    .PW        (PW)
  ) u_products (
    .clk     (clk),
    .rst     (rst),
    .load    (ready2),
    .s1_valid(s1_valid),
    .a1_x    (a1_x),
    .a1_y    (a1_y),
    .a2_x    (a2_x),
    .a2_y    (a2_y),
    .b1_x    (b1_x),
    .b1_y    (b1_y),
    .b2_x    (b2_x),
    .b2_y    (b2_y),
    .s1_flags(s1_flags),
    .s2_valid(s2_valid),
    .ori_pa  (ori_pa),
    .ori_pb  (ori_pb),
    .u_xx    (u_xx),
    .u_yy    (u_yy),
    .dot_x   (dot_x),
    .dot_y   (dot_y),
    .v_xx    (v_xx),
    .v_yy    (v_yy),
    .s2_flags(s2_flags)
  );

  sci_classify #(
    .COORD_BITS(COORD_BITS),
    .PW        (PW)
  ) u_classify (
    .clk           (clk),
    .rst           (rst),
    .load          (ready3),
    .orient_epsilon(orient_epsilon),
    .s2_valid      (s2_valid),
    .ori_pa        (ori_pa),
    .ori_pb        (ori_pb),
    .u_xx          (u_xx),
    .u_yy          (u_yy),
    .dot_x         (dot_x),
    .dot_y         (dot_y),
    .v_xx          (v_xx),
    .v_yy          (v_yy),
    .s2_flags      (s2_flags),
    .s3_valid      (s3_valid),
    .s3_class      (s3_class),
    .s3_flags      (s3_flags)
  );

  sci_decide u_decide (
    .clk         (clk),
    .rst         (rst),
    .s3_valid    (s3_valid),
    .s3_class    (s3_class),
    .s3_flags    (s3_flags),
    .ready3      (ready3),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .intersects  (intersects)
  );

  a_vertex_enters: assert property (@(posedge clk) disable iff (rst)
    accept && kind == KIND_VERTEX |=> s1_valid)
    else $error("accepted vertex did not reach the operand register");

  a_result_from_last: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(s3_valid && s3_flags.last))
    else $error("result raised without a last vertex");

  a_stage_holds: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !ready2 |=> s1_valid)
    else $error("operand register dropped a blocked pair");

  a_stall_only_full: assert property (@(posedge clk) disable iff (rst)
    item_stall |-> s1_valid && s2_valid && s3_valid && result_valid)
    else $error("input stalled with room in the pipeline");

endmodule

### sv/sci_capture.sv
`timescale 1ns / 1ps
// Input stage: query and previous-vertex state, operand register for one pair.
// Depends on sci_pkg.
module sci_capture import sci_pkg::*; #(
  parameter int COORD_BITS = 16,
  parameter int ID_BITS    = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         accept,
  input  logic                         load,
  input  logic [1:0]                   kind,
  input  logic signed [COORD_BITS-1:0] coord_x,
  input  logic signed [COORD_BITS-1:0] coord_y,
  input  logic [ID_BITS-1:0]           vertex_id,
  input  logic                         last,
  output logic                         s1_valid,
  output logic signed [COORD_BITS-1:0] a1_x,
  output logic signed [COORD_BITS-1:0] a1_y,
  output logic signed [COORD_BITS-1:0] a2_x,
  output logic signed [COORD_BITS-1:0] a2_y,
  output logic signed [COORD_BITS-1:0] b1_x,
  output logic signed [COORD_BITS-1:0] b1_y,
  output logic signed [COORD_BITS-1:0] b2_x,
  output logic signed [COORD_BITS-1:0] b2_y,
  output pair_flags_t                  s1_flags
);

  logic signed [COORD_BITS-1:0] qs_x, qs_y, qe_x, qe_y, pv_x, pv_y;
  logic [ID_BITS-1:0]           qs_id, qe_id, pv_id;
  logic                         have_prev;

  logic signed [COORD_BITS-1:0] qmin, qmax, cmin, cmax;
  logic                         overlap;
  pair_flags_t                  flags_next;

  always_comb begin
    qmin = (qs_y < qe_y) ? qs_y : qe_y;
    qmax = (qs_y > qe_y) ? qs_y : qe_y;
    cmin = (pv_y < coord_y) ? pv_y : coord_y;
    cmax = (pv_y > coord_y) ? pv_y : coord_y;
    overlap = (pv_y >= qmin && pv_y <= qmax) || (coord_y >= qmin && coord_y <= qmax) ||
              (qs_y >= cmin && qs_y <= cmax) || (qe_y >= cmin && qe_y <= cmax);
    flags_next.tested  = have_prev;
    flags_next.last    = last;
    flags_next.overlap = overlap;
    flags_next.id_a1b1 = (pv_id == qs_id);
    flags_next.id_a1b2 = (pv_id == qe_id);
    flags_next.id_a2b1 = (vertex_id == qs_id);
    flags_next.id_a2b2 = (vertex_id == qe_id);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      qs_x      <= '0;
      qs_y      <= '0;
      qs_id     <= '0;
      qe_x      <= '0;
      qe_y      <= '0;
      qe_id     <= '0;
      pv_x      <= '0;
      pv_y      <= '0;
      pv_id     <= '0;
      have_prev <= 1'b0;
      s1_valid  <= 1'b0;
    end else begin
      if (accept) begin
        case (kind)
          KIND_QSTART: begin
            qs_x  <= coord_x;
            qs_y  <= coord_y;
            qs_id <= vertex_id;
          end
          KIND_QEND: begin
            qe_x  <= coord_x;
            qe_y  <= coord_y;
            qe_id <= vertex_id;
          end
          KIND_VERTEX: begin
            pv_x      <= coord_x;
            pv_y      <= coord_y;
            pv_id     <= vertex_id;
            have_prev <= !last;
          end
          default: begin
          end
        endcase
      end
      if (load) begin
        s1_valid <= accept && (kind == KIND_VERTEX);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      a1_x     <= pv_x;
      a1_y     <= pv_y;
      a2_x     <= coord_x;
      a2_y     <= coord_y;
      b1_x     <= qs_x;
      b1_y     <= qs_y;
      b2_x     <= qe_x;
      b2_y     <= qe_y;
      s1_flags <= flags_next;
    end
  end

endmodule

### sv/sci_products.sv
`timescale 1ns / 1ps
// Product stage: coordinate differences and all orientation, dot and length products.
// Depends on sci_pkg.
module sci_products import sci_pkg::*; #(
  parameter int COORD_BITS = 16,
  parameter int PW         = 2 * COORD_BITS + 2
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         load,
  input  logic                         s1_valid,
  input  logic signed [COORD_BITS-1:0] a1_x,
  input  logic signed [COORD_BITS-1:0] a1_y,
  input  logic signed [COORD_BITS-1:0] a2_x,
  input  logic signed [COORD_BITS-1:0] a2_y,
  input  logic signed [COORD_BITS-1:0] b1_x,
  input  logic signed [COORD_BITS-1:0] b1_y,
  input  logic signed [COORD_BITS-1:0] b2_x,
  input  logic signed [COORD_BITS-1:0] b2_y,
  input  pair_flags_t                  s1_flags,
  output logic                         s2_valid,
  output logic signed [PW-1:0]         ori_pa [4],
  output logic signed [PW-1:0]         ori_pb [4],
  output logic signed [PW-1:0]         u_xx,
  output logic signed [PW-1:0]         u_yy,
  output logic signed [PW-1:0]         dot_x [2],
  output logic signed [PW-1:0]         dot_y [2],
  output logic signed [PW-1:0]         v_xx [2],
  output logic signed [PW-1:0]         v_yy [2],
  output pair_flags_t                  s2_flags
);

  localparam int DW = COORD_BITS + 1;

  function automatic logic signed [DW-1:0] sx(input logic signed [COORD_BITS-1:0] v);
    sx = $signed({v[COORD_BITS-1], v});
  endfunction

  function automatic logic signed [PW-1:0] mul(input logic signed [DW-1:0] p,
                                               input logic signed [DW-1:0] q);
    mul = PW'(p) * PW'(q);
  endfunction

  logic signed [DW-1:0] dax, day, dbx, dby;
  logic signed [DW-1:0] b1ax, b1ay, b2ax, b2ay;
  logic signed [DW-1:0] a1bx, a1by, a2bx, a2by;
  logic signed [DW-1:0] v1x, v1y, v2x, v2y;

  always_comb begin
    dax  = sx(a2_x) - sx(a1_x);
    day  = sx(a2_y) - sx(a1_y);
    dbx  = sx(b2_x) - sx(b1_x);
    dby  = sx(b2_y) - sx(b1_y);
    b1ax = sx(b1_x) - sx(a2_x);
    b1ay = sx(b1_y) - sx(a2_y);
    b2ax = sx(b2_x) - sx(a2_x);
    b2ay = sx(b2_y) - sx(a2_y);
    a1bx = sx(a1_x) - sx(b2_x);
    a1by = sx(a1_y) - sx(b2_y);
    a2bx = sx(a2_x) - sx(b2_x);
    a2by = sx(a2_y) - sx(b2_y);
    v1x  = sx(b1_x) - sx(a1_x);
    v1y  = sx(b1_y) - sx(a1_y);
    v2x  = sx(b2_x) - sx(a1_x);
    v2y  = sx(b2_y) - sx(a1_y);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (load) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      ori_pa[0] <= mul(day, b1ax);
      ori_pb[0] <= mul(b1ay, dax);
      ori_pa[1] <= mul(day, b2ax);
      ori_pb[1] <= mul(b2ay, dax);
      ori_pa[2] <= mul(dby, a1bx);
      ori_pb[2] <= mul(a1by, dbx);
      ori_pa[3] <= mul(dby, a2bx);
      ori_pb[3] <= mul(a2by, dbx);
      u_xx      <= mul(dax, dax);
      u_yy      <= mul(day, day);
      dot_x[0]  <= mul(dax, v1x);
      dot_y[0]  <= mul(day, v1y);
      v_xx[0]   <= mul(v1x, v1x);
      v_yy[0]   <= mul(v1y, v1y);
      dot_x[1]  <= mul(dax, v2x);
      dot_y[1]  <= mul(day, v2y);
      v_xx[1]   <= mul(v2x, v2x);
      v_yy[1]   <= mul(v2y, v2y);
      s2_flags  <= s1_flags;
    end
  end

endmodule

### sv/sci_classify.sv
`timescale 1ns / 1ps
// Sign stage: thresholded orientations and far-collinear flags from the products.
// Depends on sci_pkg.
module sci_classify import sci_pkg::*; #(
  parameter int COORD_BITS = 16,
  parameter int PW         = 2 * COORD_BITS + 2
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 load,
  input  logic [EPS_W-1:0]     orient_epsilon,
  input  logic                 s2_valid,
  input  logic signed [PW-1:0] ori_pa [4],
  input  logic signed [PW-1:0] ori_pb [4],
  input  logic signed [PW-1:0] u_xx,
  input  logic signed [PW-1:0] u_yy,
  input  logic signed [PW-1:0] dot_x [2],
  input  logic signed [PW-1:0] dot_y [2],
  input  logic signed [PW-1:0] v_xx [2],
  input  logic signed [PW-1:0] v_yy [2],
  input  pair_flags_t          s2_flags,
  output logic                 s3_valid,
  output pair_class_t          s3_class,
  output pair_flags_t          s3_flags
);

  localparam int SW = PW + 1;
  localparam int OW = (SW > EPS_W + 1) ? SW : EPS_W + 1;

  function automatic logic signed [SW-1:0] ext(input logic signed [PW-1:0] v);
    ext = $signed({v[PW-1], v});
  endfunction

  logic signed [OW-1:0] eps_pos, eps_neg;
  logic signed [SW-1:0] ori_val [4];
  logic signed [OW-1:0] ori_wide [4];
  logic signed [SW-1:0] len_u;
  logic signed [SW-1:0] len_v [2];
  logic signed [SW-1:0] dot [2];
  pair_class_t          class_next;

  always_comb begin
    eps_pos = $signed(OW'({1'b0, orient_epsilon}));
    eps_neg = -eps_pos;
    for (int k = 0; k < 4; k++) begin
      ori_val[k]  = ext(ori_pa[k]) - ext(ori_pb[k]);
      ori_wide[k] = OW'(ori_val[k]);
      if (ori_wide[k] > eps_pos) begin
        class_next.ori[k] = ORI_CW;
      end else if (ori_wide[k] < eps_neg) begin
        class_next.ori[k] = ORI_CCW;
      end else begin
        class_next.ori[k] = ORI_COL;
      end
    end
    len_u = ext(u_xx) + ext(u_yy);
    for (int r = 0; r < 2; r++) begin
      dot[r]            = ext(dot_x[r]) + ext(dot_y[r]);
      len_v[r]          = ext(v_xx[r]) + ext(v_yy[r]);
      class_next.far[r] = !dot[r][SW-1] && !(len_v[r] > len_u);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else if (load) begin
      s3_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      s3_class <= class_next;
      s3_flags <= s2_flags;
    end
  end

endmodule

### sv/sci_decide.sv
`timescale 1ns / 1ps
// Decision stage: inclusive / non-inclusive hit, sticky flag and result register.
// Depends on sci_pkg.
module sci_decide import sci_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s3_valid,
  input  pair_class_t s3_class,
  input  pair_flags_t s3_flags,
  output logic        ready3,
  output logic        result_valid,
  input  logic        result_stall,
  output logic        intersects
);

  logic [3:0] col;
  logic       general, all_col, shared, incl, excl, hit, out_ready, consume;
  logic       hit_acc;

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      col[k] = (s3_class.ori[k] == ORI_COL);
    end
    general = (s3_class.ori[0] != s3_class.ori[1]) && (s3_class.ori[2] != s3_class.ori[3]);
    all_col = &col;
    shared  = s3_flags.id_a1b1 || s3_flags.id_a1b2 || s3_flags.id_a2b1 || s3_flags.id_a2b2;
    incl    = general || (all_col && (s3_class.far[0] || s3_class.far[1]));
    // shared-id case: only collinear overlap past a query point not on the curve pair
    excl    = all_col &&
              ((!s3_flags.id_a1b1 && !s3_flags.id_a2b1 && s3_class.far[0]) ||
               (!s3_flags.id_a1b2 && !s3_flags.id_a2b2 && s3_class.far[1]));
    hit     = s3_flags.tested && s3_flags.overlap && (shared ? excl : incl);
    out_ready = !result_valid || !result_stall;
    ready3    = !s3_valid || !s3_flags.last || out_ready;
    consume   = s3_valid && ready3;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hit_acc      <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (consume && s3_flags.last) begin
        hit_acc      <= 1'b0;
        result_valid <= 1'b1;
      end else begin
        if (consume) begin
          hit_acc <= hit_acc || hit;
        end
        if (!result_stall) begin
          result_valid <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (consume && s3_flags.last) begin
      intersects <= hit_acc || hit;
    end
  end

endmodule

### sim/tb_segment_curve_intersection_test.sv
`timescale 1ns / 1ps
// Testbench for segment_curve_intersection_test: directed shapes, then random query/curve
// traffic checked against a cycle-free hit predictor. Depends on sci_pkg and the block RTL.
module tb_segment_curve_intersection_test;
  import sci_pkg::*;

  localparam int COORD_W = 16;
  localparam int ID_W = 16;
  localparam logic [1:0] KIND_UNUSED = 2'd3;
  localparam logic [PADDR_W-1:0] EPS_ADDR = PADDR_W'(4 * REG_ORIENT_EPS);
  localparam int PIPE_SETTLE = 8;
  localparam int QUIET_LIMIT = 2000;
  localparam int HOLDOFF_CYCLES = 300;

  typedef struct {
    longint x;
    longint y;
    logic [ID_W-1:0] id;
  } vertex_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic item_valid = 1'b0;
  logic item_stall;
  logic [1:0] kind = KIND_QSTART;
  logic signed [COORD_W-1:0] coord_x = '0;
  logic signed [COORD_W-1:0] coord_y = '0;
  logic [ID_W-1:0] vertex_id = '0;
  logic last = 1'b0;
  logic result_valid;
  logic result_stall = 1'b0;
  logic intersects;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [PDATA_W-1:0] pwdata = '0;
  logic [PDATA_W-1:0] prdata;
  logic pready;

  // predictor state
  vertex_t q_start, q_end, prev_v;
  bit have_prev, hit_seen;
  logic [EPS_W-1:0] eps_shadow = '0;
  logic pending_hits[$];

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int result_hold_cycles = 0;
  int items_sent = 0;
  int errors = 0;
  int quiet_cycles = 0;

  segment_curve_intersection_test #(
    .COORD_BITS(COORD_W),
    .ID_BITS(ID_W)
  ) dut (
    .clk(clk), .rst(rst),
    .item_valid(item_valid), .item_stall(item_stall),
    .kind(kind), .coord_x(coord_x), .coord_y(coord_y), .vertex_id(vertex_id), .last(last),
    .result_valid(result_valid), .result_stall(result_stall), .intersects(intersects),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
    .prdata(prdata), .pready(pready)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  function automatic ori_t orient_of(vertex_t a, vertex_t b, vertex_t c);
    longint o, e;
    o = (b.y - a.y) * (c.x - b.x) - (c.y - b.y) * (b.x - a.x);
    e = {32'd0, eps_shadow};
    if (o > e) return ORI_CW;
    if (o < -e) return ORI_CCW;
    return ORI_COL;
  endfunction

  // q is the far end of the collinear triple (p, q, r)
  function automatic bit q_is_far(vertex_t p, vertex_t q, vertex_t r);
    longint ux, uy, vx, vy;
    ux = q.x - p.x;
    uy = q.y - p.y;
    vx = r.x - p.x;
    vy = r.y - p.y;
    if (ux * vx + uy * vy < 0) return 1'b0;
    return !(vx * vx + vy * vy > ux * ux + uy * uy);
  endfunction

  function automatic bit crosses_closed(vertex_t a1, vertex_t a2, vertex_t b1, vertex_t b2);
    ori_t o1, o2, o3, o4;
    o1 = orient_of(a1, a2, b1);
    o2 = orient_of(a1, a2, b2);
    o3 = orient_of(b1, b2, a1);
    o4 = orient_of(b1, b2, a2);
    if (o1 != o2 && o3 != o4) return 1'b1;
    if (o1 == ORI_COL && o2 == ORI_COL && o3 == ORI_COL && o4 == ORI_COL)
      return q_is_far(a1, a2, b1) || q_is_far(a1, a2, b2);
    return 1'b0;
  endfunction

  function automatic bit crosses_open(vertex_t a1, vertex_t a2, vertex_t b1, vertex_t b2);
    ori_t o1, o2, o3, o4;
    bit shared;
    o1 = orient_of(a1, a2, b1);
    o2 = orient_of(a1, a2, b2);
    o3 = orient_of(b1, b2, a1);
    o4 = orient_of(b1, b2, a2);
    shared = a1.id == b1.id || a1.id == b2.id || a2.id == b1.id || a2.id == b2.id;
    if (!shared) begin
      if ((o1 == ORI_COL) != (o2 == ORI_COL) || (o3 == ORI_COL) != (o4 == ORI_COL))
        return 1'b0;
      if (o1 != o2 && o3 != o4) return 1'b1;
    end
    if (o1 == ORI_COL && o2 == ORI_COL && o3 == ORI_COL && o4 == ORI_COL) begin
      if (a1.id != b1.id && a2.id != b1.id && q_is_far(a1, a2, b1)) return 1'b1;
      if (a1.id != b2.id && a2.id != b2.id && q_is_far(a1, a2, b2)) return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic bit in_span(longint v, longint lo, longint hi);
    return v >= lo && v <= hi;
  endfunction

  function automatic bit pair_hits(vertex_t c1, vertex_t c2);
    longint qmin, qmax, cmin, cmax;
    qmin = (q_start.y < q_end.y) ? q_start.y : q_end.y;
    qmax = (q_start.y > q_end.y) ? q_start.y : q_end.y;
    cmin = (c1.y < c2.y) ? c1.y : c2.y;
    cmax = (c1.y > c2.y) ? c1.y : c2.y;
    if (!(in_span(c1.y, qmin, qmax) || in_span(c2.y, qmin, qmax) ||
          in_span(q_start.y, cmin, cmax) || in_span(q_end.y, cmin, cmax)))
      return 1'b0;
    if (q_start.id != c1.id && q_start.id != c2.id && q_end.id != c1.id && q_end.id != c2.id)
      return crosses_closed(c1, c2, q_start, q_end);
    return crosses_open(c1, c2, q_start, q_end);
  endfunction

  function automatic void update_hit_prediction(logic [1:0] k, vertex_t v, logic lst);
    case (k)
      KIND_QSTART: q_start = v;
      KIND_QEND: q_end = v;
      KIND_VERTEX: begin
        if (have_prev && pair_hits(prev_v, v)) hit_seen = 1'b1;
        prev_v = v;
        have_prev = 1'b1;
        if (lst) begin
          pending_hits.push_back(hit_seen);
          have_prev = 1'b0;
          hit_seen = 1'b0;
        end
      end
      default: ;
    endcase
  endfunction

  function automatic logic signed [COORD_W-1:0] pick_coord(int span);
    if (span == 0) return COORD_W'($urandom);
    return COORD_W'(int'($urandom_range(0, 2 * span)) - span);
  endfunction

  function automatic logic [ID_W-1:0] pick_id();
    if ($urandom_range(99) < 70) return ID_W'($urandom_range(0, 7));
    return ID_W'($urandom);
  endfunction

  task automatic send_item(input logic [1:0] k, input logic signed [COORD_W-1:0] x,
                           input logic signed [COORD_W-1:0] y, input logic [ID_W-1:0] id,
                           input logic lst);
    vertex_t v;
    while ($urandom_range(99) < send_idle_pct) begin
      item_valid <= 1'b0;
      @(posedge clk);
    end
    item_valid <= 1'b1;
    kind <= k;
    coord_x <= x;
    coord_y <= y;
    vertex_id <= id;
    last <= lst;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    v.x = x;
    v.y = y;
    v.id = id;
    update_hit_prediction(k, v, lst);
    if (k != KIND_UNUSED) items_sent++;
  endtask

  task automatic drain();
    item_valid <= 1'b0;
    while (pending_hits.size() != 0) @(posedge clk);
    repeat (PIPE_SETTLE) @(posedge clk);
  endtask

  task automatic write_orient_eps(input logic [EPS_W-1:0] value);
    drain();
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= EPS_ADDR;
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    eps_shadow = value;
  endtask

  task automatic test_known_shapes();
    send_idle_pct = 31;
    recv_idle_pct = 76;
    // full-range diagonals crossing next to the origin
    send_item(KIND_QSTART, -16'sd32768, -16'sd32768, 16'd0, 1'b0);
    send_item(KIND_QEND, 16'sd32767, 16'sd32767, 16'hffff, 1'b0);
    send_item(KIND_VERTEX, -16'sd32768, 16'sd32767, 16'd1, 1'b0);
    send_item(KIND_VERTEX, 16'sd32767, -16'sd32768, 16'd2, 1'b1);
    // collinear overlap, no shared id
    send_item(KIND_QSTART, 16'sd0, 16'sd0, 16'd7, 1'b0);
    send_item(KIND_QEND, 16'sd10, 16'sd0, 16'd8, 1'b0);
    send_item(KIND_VERTEX, 16'sd5, 16'sd0, 16'd1, 1'b0);
    send_item(KIND_VERTEX, 16'sd15, 16'sd0, 16'd2, 1'b1);
    // shared end vertex: collinear continuation, then a turn that misses the query
    send_item(KIND_VERTEX, 16'sd10, 16'sd0, 16'd8, 1'b0);
    send_item(KIND_VERTEX, 16'sd20, 16'sd0, 16'd9, 1'b0);
    send_item(KIND_VERTEX, 16'sd20, 16'sd10, 16'd10, 1'b1);
    // y ranges apart
    send_item(KIND_VERTEX, 16'sd0, 16'sd5, 16'd3, 1'b0);
    send_item(KIND_VERTEX, 16'sd3, 16'sd9, 16'd4, 1'b1);
  endtask

  task automatic test_ignored_items();
    send_item(KIND_UNUSED, 16'sd1, 16'sd1, 16'd1, 1'b1);
    send_item(KIND_QEND, 16'sd10, 16'sd10, 16'd8, 1'b1);
    send_item(KIND_VERTEX, 16'sd5, 16'sd5, 16'd5, 1'b1);
    // query swapped between the two vertices of a segment
    send_item(KIND_VERTEX, 16'sd0, 16'sd10, 16'd3, 1'b0);
    send_item(KIND_QSTART, 16'sd0, -16'sd10, 16'd11, 1'b0);
    send_item(KIND_VERTEX, 16'sd10, -16'sd5, 16'd12, 1'b1);
  endtask

  task automatic test_orient_eps_extremes();
    write_orient_eps('1);
    send_item(KIND_QSTART, 16'sd0, 16'sd0, 16'd20, 1'b0);
    send_item(KIND_QEND, 16'sd100, 16'sd1, 16'd21, 1'b0);
    send_item(KIND_VERTEX, 16'sd50, -16'sd1, 16'd22, 1'b0);
    send_item(KIND_VERTEX, 16'sd150, 16'sd2, 16'd23, 1'b1);
    write_orient_eps('0);
  endtask

  task automatic send_random_curve();
    int span, n, i, roll;
    logic signed [COORD_W-1:0] x, y;
    logic [ID_W-1:0] id;
    roll = $urandom_range(99);
    span = (roll < 65) ? 16 : (roll < 85) ? 1000 : 0;
    roll = $urandom_range(99);
    if (roll < 60) begin
      send_item(KIND_QSTART, pick_coord(span), pick_coord(span), pick_id(),
                1'($urandom_range(1)));
      send_item(KIND_QEND, pick_coord(span), pick_coord(span), pick_id(),
                1'($urandom_range(1)));
    end else if (roll < 75) begin
      send_item($urandom_range(1) ? KIND_QEND : KIND_QSTART, pick_coord(span),
                pick_coord(span), pick_id(), 1'($urandom_range(1)));
    end
    n = $urandom_range(1, 6);
    for (i = 0; i < n; i++) begin
      roll = $urandom_range(99);
      if (roll < 3)
        send_item(KIND_UNUSED, COORD_W'($urandom), COORD_W'($urandom), ID_W'($urandom),
                  1'($urandom_range(1)));
      else if (roll < 6)
        send_item($urandom_range(1) ? KIND_QEND : KIND_QSTART, pick_coord(span),
                  pick_coord(span), pick_id(), 1'($urandom_range(1)));
      roll = $urandom_range(99);
      if (roll < 15) begin
        x = COORD_W'(q_start.x);
        y = COORD_W'(q_start.y);
        id = q_start.id;
      end else if (roll < 30) begin
        x = COORD_W'(q_end.x);
        y = COORD_W'(q_end.y);
        id = q_end.id;
      end else begin
        x = pick_coord(span);
        y = pick_coord(span);
        id = pick_id();
      end
      send_item(KIND_VERTEX, x, y, id, i == n - 1);
    end
  endtask

  task automatic test_random_curves(input int send_pct, input int recv_pct,
                                    input logic [EPS_W-1:0] eps, input int count);
    int start;
    write_orient_eps(eps);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    start = items_sent;
    while (items_sent - start < count) send_random_curve();
  endtask

  // receiver stops for a long stretch while two-vertex curves keep coming
  task automatic test_output_holdoff();
    int i;
    drain();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    result_hold_cycles = HOLDOFF_CYCLES;
    for (i = 0; i < 12; i++) begin
      send_item(KIND_VERTEX, pick_coord(16), pick_coord(16), pick_id(), 1'b0);
      send_item(KIND_VERTEX, pick_coord(16), pick_coord(16), pick_id(), 1'b1);
    end
  endtask

  always @(posedge clk) begin : result_check
    logic want;
    if (!rst && result_valid && !result_stall) begin
      if (pending_hits.size() == 0) begin
        errors++;
        $display("%0t: unexpected transfer, expected none, actual intersects=%0b",
                 $time, intersects);
      end else begin
        want = pending_hits.pop_front();
        if (intersects !== want) begin
          errors++;
          $display("%0t: intersects mismatch, expected %0b, actual %0b",
                   $time, want, intersects);
        end
      end
    end
    if (result_hold_cycles > 0) begin
      result_stall <= 1'b1;
      result_hold_cycles--;
    end else begin
      result_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if ((item_valid && !item_stall) || (result_valid && !result_stall) || (psel && penable)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_LIMIT) begin
      $display("tb_segment_curve_intersection_test: done, errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_known_shapes();
    test_ignored_items();
    test_orient_eps_extremes();
    test_random_curves(31, 76, '0, 300);
    test_output_holdoff();
    test_random_curves(76, 31, EPS_W'($urandom_range(1, 64)), 300);
    test_random_curves(0, 0, EPS_W'($urandom), 300);
    drain();
    if (errors == 0) begin
      $display("tb_segment_curve_intersection_test: done, clean");
    end else begin
      $display("tb_segment_curve_intersection_test: done, errors");
    end
    $finish;
  end

endmodule
